/* rtl/core/assert_macros.svh */
// Assertion macros shared by the prime field arithmetic unit RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

/* rtl/core/pfau_pkg.sv */
// Package of the prime field arithmetic unit: field widths, operation codes and shared types.
// Depends on nothing; used by the interfaces, the RTL modules and the testbench.
`timescale 1ns / 1ps

package pfau_pkg;

	// Default field: GF(929) with generator 3.
	localparam int DEF_MODULUS   = 929;
	localparam int DEF_GENERATOR = 3;

	// Fixed widths of the transaction fields.
	localparam int OP_W   = 3;
	localparam int OPND_W = 10;
	localparam int RES_W  = 10;

	// Fraction bits of the reciprocal used to reduce operands modulo the prime.
	localparam int RECIP_SHIFT = 20;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_INV = 3'd3,
		OP_EXP = 3'd4,
		OP_LOG = 3'd5
	} op_t;

	// States of the table build sequencer.
	typedef enum logic [1:0] {
		INIT_CLEAR,
		INIT_FILL,
		INIT_DONE
	} init_state_t;

	// Read enables of the table memories.
	typedef struct packed {
		logic log_en;
		logic pow_en;
	} pfau_rd_t;

endpackage

/* rtl/core/pfau_if.sv */
// Channel interfaces of the prime field arithmetic unit: request and response.
// Depends on pfau_pkg for the field widths.
`timescale 1ns / 1ps

interface pfau_req_if;
	import pfau_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     req_type;
	logic [OPND_W-1:0]   operand_a;
	logic [OPND_W-1:0]   operand_b;

	modport source (output valid, req_type, operand_a, operand_b, input ready);
	modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface pfau_rsp_if;
	import pfau_pkg::*;

	logic                valid;
	logic                ready;
	logic [RES_W-1:0]    result_value;
	logic                error_flag;

	modport source (output valid, result_value, error_flag, input ready);
	modport sink (input valid, result_value, error_flag, output ready);
endinterface

/* rtl/core/prime_field_arithmetic_unit.sv */
// Top level of the prime field arithmetic unit: six-stage pipeline around the table memories.
// Depends on pfau_pkg, pfau_if, pfau_reduce, pfau_tables and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Arithmetic over GF(MODULUS): add, subtract, multiply, inverse, exp and log, one result
// transaction per request transaction, in order. After reset the unit builds its power and
// log tables and holds req.ready low until the build is done; the table build steps through
// the powers of the generator with a bit-serial modular multiply, one generator bit per
// cycle. After that it takes one request per cycle while the output is not stalled, and each
// result passes through the stages in order: two stages reduce the operands, one reads the
// log table, one forms the power table address, one reads the power table, and the last
// selects the result. The pipeline holds under back pressure without loss, and empty stages
// still fill while the output waits.
module prime_field_arithmetic_unit #(
	parameter int MODULUS   = pfau_pkg::DEF_MODULUS,
	parameter int GENERATOR = pfau_pkg::DEF_GENERATOR
) (
	input  logic          clk,
	input  logic          arst_n,
	pfau_req_if.sink      req,
	pfau_rsp_if.source    rsp
);
	import pfau_pkg::*;

	localparam int EW = $clog2(MODULUS);
	localparam logic [EW:0]   MOD_C = (EW + 1)'(MODULUS);
	localparam logic [EW-1:0] ORD_C = EW'(MODULUS - 1);

	logic tbl_ready;
	logic in_fire;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [OP_W-1:0] op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [EW-1:0]   a_s2, b_s2;
	logic [EW-1:0]   a_s3, arith_s3, la_s3, lb_s3;
	logic            za_s3, zb_s3;
	logic [EW-1:0]   paddr_s4, arith_s4, la_s4;
	logic            za_s4, zb_s4;
	logic [EW-1:0]   pw_s5, arith_s5, la_s5;
	logic            za_s5, zb_s5;
	logic [EW-1:0]   res_s6;
	logic            err_s6;

	logic [EW:0]     sum_w, dif_w, lsum_w;
	logic [EW-1:0]   sum_m, dif_m, lsum_m, arith, paddr;
	logic [EW-1:0]   res;
	logic            err;
	pfau_rd_t        rd_en;

	// A stage takes new contents when it is empty or its successor moves on.
	assign rdy_s6 = !v_s6 || rsp.ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign req.ready = rdy_s1 && tbl_ready;
	assign in_fire   = req.valid && req.ready;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_fire;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Operation code follows the operands down the pipeline.
	always_ff @(posedge clk) begin
		if (rdy_s1) op_s1 <= req.req_type;
		if (rdy_s2) op_s2 <= op_s1;
		if (rdy_s3) op_s3 <= op_s2;
		if (rdy_s4) op_s4 <= op_s3;
		if (rdy_s5) op_s5 <= op_s4;
	end

	// Stages 1 and 2: operands reduced modulo the prime.
	pfau_reduce #(.MODULUS(MODULUS)) u_red_a (
		.clk        (clk),
		.en_s1      (rdy_s1),
		.en_s2      (rdy_s2),
		.value      (req.operand_a),
		.residue_s2 (a_s2)
	);

	pfau_reduce #(.MODULUS(MODULUS)) u_red_b (
		.clk        (clk),
		.en_s1      (rdy_s1),
		.en_s2      (rdy_s2),
		.value      (req.operand_b),
		.residue_s2 (b_s2)
	);

	// Table memories; log reads land in stage 3, power reads in stage 5.
	assign rd_en = '{log_en: rdy_s3, pow_en: rdy_s5};

	pfau_tables #(.MODULUS(MODULUS), .GENERATOR(GENERATOR)) u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.ready      (tbl_ready),
		.rd_en      (rd_en),
		.log_addr_a (a_s2),
		.log_addr_b (b_s2),
		.log_data_a (la_s3),
		.log_data_b (lb_s3),
		.pow_addr   (paddr_s4),
		.pow_data   (pw_s5)
	);

	// Stage 3: modular add and subtract alongside the log reads.
	assign sum_w = {1'b0, a_s2} + {1'b0, b_s2};
	assign sum_m = (sum_w >= MOD_C) ? EW'(sum_w - MOD_C) : sum_w[EW-1:0];
	assign dif_w = {1'b0, a_s2} - {1'b0, b_s2};
	assign dif_m = (a_s2 < b_s2) ? EW'(dif_w + MOD_C) : dif_w[EW-1:0];
	assign arith = (op_s2 == OP_SUB) ? dif_m : sum_m;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			a_s3     <= a_s2;
			arith_s3 <= arith;
			za_s3    <= (a_s2 == '0);
			zb_s3    <= (b_s2 == '0);
		end
	end

	// Stage 4: power table address. Logs sum modulo the group order for multiply, and
	// the inverse uses the complement of the log, which is always below the prime.
	assign lsum_w = {1'b0, la_s3} + {1'b0, lb_s3};
	assign lsum_m = (lsum_w >= {1'b0, ORD_C}) ? EW'(lsum_w - {1'b0, ORD_C}) : lsum_w[EW-1:0];

	always_comb begin
		unique case (op_s3)
			OP_MUL:  paddr = lsum_m;
			OP_INV:  paddr = ORD_C - la_s3;
			default: paddr = a_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			paddr_s4 <= paddr;
			arith_s4 <= arith_s3;
			la_s4    <= la_s3;
			za_s4    <= za_s3;
			zb_s4    <= zb_s3;
		end
	end

	// Stage 5: power table read in flight; side data waits beside it.
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			arith_s5 <= arith_s4;
			la_s5    <= la_s4;
			za_s5    <= za_s4;
			zb_s5    <= zb_s4;
		end
	end

	// Stage 6: result selection into the output register.
	always_comb begin
		res = '0;
		err = 1'b0;
		unique case (op_s5) inside
			OP_ADD, OP_SUB: res = arith_s5;
			OP_MUL: res = (za_s5 || zb_s5) ? '0 : pw_s5;
			OP_INV: begin
				err = za_s5;
				res = za_s5 ? '0 : pw_s5;
			end
			OP_EXP: res = pw_s5;
			OP_LOG: begin
				err = za_s5;
				res = za_s5 ? '0 : la_s5;
			end
			default: begin
				res = '0;
				err = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			res_s6 <= res;
			err_s6 <= err;
		end
	end

	assign rsp.valid        = v_s6;
	assign rsp.result_value = RES_W'(res_s6);
	assign rsp.error_flag   = err_s6;

	`ASSERT_AT(a_res_in_field, clk, arst_n, v_s6 |-> ({1'b0, res_s6} < MOD_C),
		"result outside the field")
	`ASSERT_AT(a_err_zero, clk, arst_n, (v_s6 && err_s6) |-> (res_s6 == '0),
		"error transaction with nonzero value")
	`ASSERT_NEVER(a_idle_in_build, clk, arst_n,
		!tbl_ready && (v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6),
		"transaction in flight during table build")

endmodule

/* rtl/core/pfau_reduce.sv */
// Two-stage reduction of a raw operand modulo the prime by reciprocal multiplication.
// Depends on pfau_pkg.
`timescale 1ns / 1ps

module pfau_reduce #(
	parameter int MODULUS = pfau_pkg::DEF_MODULUS,
	localparam int EW = $clog2(MODULUS)
) (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [pfau_pkg::OPND_W-1:0]   value,
	output logic [EW-1:0]                 residue_s2
);
	import pfau_pkg::*;

	localparam int PROD_W = OPND_W + RECIP_SHIFT;
	localparam int QM_W   = OPND_W + EW;
	localparam logic [RECIP_SHIFT-1:0] RECIP_C = RECIP_SHIFT'((1 << RECIP_SHIFT) / MODULUS);
	localparam logic [EW:0]            MOD_C   = (EW + 1)'(MODULUS);

	logic [PROD_W-1:0] prod;
	logic [OPND_W-1:0] quot_s1;
	logic [OPND_W-1:0] value_s1;
	logic [QM_W-1:0]   qm;
	logic [QM_W-1:0]   diff;
	logic [EW:0]       rem;

	// Quotient estimate: never high, at most one below the true quotient.
	assign prod = PROD_W'(value) * PROD_W'(RECIP_C);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			value_s1 <= value;
			quot_s1  <= prod[PROD_W-1:RECIP_SHIFT];
		end
	end

	// The remainder is below twice the prime, so one conditional subtract finishes it.
	assign qm   = QM_W'(quot_s1) * QM_W'(MOD_C);
	assign diff = QM_W'(value_s1) - qm;
	assign rem  = diff[EW:0];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			residue_s2 <= (rem >= MOD_C) ? EW'(rem - MOD_C) : rem[EW-1:0];
		end
	end

endmodule

/* rtl/core/pfau_tables.sv */
// Power and log table memories with the sequencer that builds them after reset.
// Depends on pfau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfau_tables #(
	parameter int MODULUS   = pfau_pkg::DEF_MODULUS,
	parameter int GENERATOR = pfau_pkg::DEF_GENERATOR,
	localparam int EW = $clog2(MODULUS)
) (
	input  logic                clk,
	input  logic                arst_n,
	output logic                ready,
	input  pfau_pkg::pfau_rd_t  rd_en,
	input  logic [EW-1:0]       log_addr_a,
	input  logic [EW-1:0]       log_addr_b,
	output logic [EW-1:0]       log_data_a,
	output logic [EW-1:0]       log_data_b,
	input  logic [EW-1:0]       pow_addr,
	output logic [EW-1:0]       pow_data
);
	import pfau_pkg::*;

	localparam int BW = $clog2(EW);
	localparam logic [EW-1:0] LAST_C  = EW'(MODULUS - 1);
	localparam logic [EW:0]   MOD_C   = (EW + 1)'(MODULUS);
	localparam logic [EW-1:0] GEN_C   = EW'(GENERATOR % MODULUS);
	localparam logic [BW-1:0] TOP_BIT = BW'(EW - 1);

	logic [EW-1:0] pow_mem [MODULUS];
	logic [EW-1:0] log_mem [MODULUS];

	init_state_t   state_q, state_d;
	logic [EW-1:0] idx_q, idx_d;
	logic [EW-1:0] x_q, x_d;
	logic [EW-1:0] acc_q, acc_d;
	logic [BW-1:0] bit_q, bit_d;

	logic          first;
	logic [EW-1:0] base;
	logic [EW:0]   dbl_w;
	logic [EW-1:0] dbl;
	logic [EW:0]   add_w;
	logic [EW-1:0] step;
	logic          log_we;
	logic          pow_we;
	logic [EW-1:0] log_wa;
	logic [EW-1:0] log_wd;

	// One Horner step of x times the generator, most significant generator bit first.
	assign first = (bit_q == TOP_BIT);
	assign base  = first ? '0 : acc_q;
	assign dbl_w = {base, 1'b0};
	assign dbl   = (dbl_w >= MOD_C) ? EW'(dbl_w - MOD_C) : dbl_w[EW-1:0];
	assign add_w = {1'b0, dbl} + {1'b0, x_q};
	assign step  = GEN_C[bit_q] ? ((add_w >= MOD_C) ? EW'(add_w - MOD_C) : add_w[EW-1:0])
		: dbl;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INIT_CLEAR;
			idx_q   <= '0;
			x_q     <= '0;
			acc_q   <= '0;
			bit_q   <= TOP_BIT;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			x_q     <= x_d;
			acc_q   <= acc_d;
			bit_q   <= bit_d;
		end
	end

	// Clear the log table, then walk the powers of the generator and record each one.
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		x_d     = x_q;
		acc_d   = acc_q;
		bit_d   = bit_q;
		log_we  = 1'b0;
		pow_we  = 1'b0;
		log_wa  = idx_q;
		log_wd  = '0;
		unique case (state_q)
			INIT_CLEAR: begin
				log_we = 1'b1;
				if (idx_q == LAST_C) begin
					state_d = INIT_FILL;
					idx_d   = '0;
					x_d     = EW'(1);
					bit_d   = TOP_BIT;
				end else begin
					idx_d = idx_q + EW'(1);
				end
			end
			INIT_FILL: begin
				pow_we = first;
				log_we = first && (idx_q != LAST_C);
				log_wa = x_q;
				log_wd = idx_q;
				if (bit_q == '0) begin
					x_d   = step;
					bit_d = TOP_BIT;
					if (idx_q == LAST_C) begin
						state_d = INIT_DONE;
					end else begin
						idx_d = idx_q + EW'(1);
					end
				end else begin
					bit_d = bit_q - BW'(1);
					acc_d = step;
				end
			end
			INIT_DONE: begin
			end
			default: begin
				state_d = INIT_CLEAR;
			end
		endcase
	end

	assign ready = (state_q == INIT_DONE);

	// Write ports.
	always_ff @(posedge clk) begin
		if (log_we) begin
			log_mem[log_wa] <= log_wd;
		end
		if (pow_we) begin
			pow_mem[idx_q] <= x_q;
		end
	end

	// Registered read ports, held while the owning pipeline stage stalls.
	always_ff @(posedge clk) begin
		if (rd_en.log_en) begin
			log_data_a <= log_mem[log_addr_a];
			log_data_b <= log_mem[log_addr_b];
		end
		if (rd_en.pow_en) begin
			pow_data <= pow_mem[pow_addr];
		end
	end

	`ASSERT_AT(a_x_in_field, clk, arst_n, (state_q == INIT_FILL) |-> ({1'b0, x_q} < MOD_C), "power left the field")
	`ASSERT_AT(a_acc_in_field, clk, arst_n, (state_q == INIT_FILL && !first) |-> ({1'b0, acc_q} < MOD_C), "partial product left the field")
	`ASSERT_AT(a_done_sticky, clk, arst_n, (state_q == INIT_DONE) |=> (state_q == INIT_DONE), "table build restarted")

endmodule

/* tb/tb_prime_field_arithmetic_unit.sv */
// Testbench of the GF(929) prime field arithmetic unit: directed and random field operations,
// checked against an in-bench predictor that builds its own power and log tables.
// Depends on pfau_pkg, pfau_if and the prime_field_arithmetic_unit RTL.
`timescale 1ns / 1ps

module tb_prime_field_arithmetic_unit;
	import pfau_pkg::*;

	localparam int unsigned FIELD_MOD = DEF_MODULUS;
	localparam int unsigned FIELD_GEN = DEF_GENERATOR;

	// Operation codes the unit does not define; they must answer 0 without error.
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam int RANDOM_REQS = 1825;
	localparam int TAIL_REQS   = 150;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		bit                drain_first;
	} field_req_t;

	typedef struct packed {
		logic [RES_W-1:0] value;
		logic             err;
	} field_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pfau_req_if req ();
	pfau_rsp_if rsp ();

	prime_field_arithmetic_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Predictor tables and queues.
	int unsigned   pow_tab [FIELD_MOD];
	int unsigned   dlog_tab [FIELD_MOD];
	field_req_t    pending_ops [$];
	field_result_t awaited_results [$];

	field_req_t    next_req;
	field_result_t predicted;
	field_result_t observed;
	field_result_t oldest;

	int total_reqs;
	int accepted_reqs;
	int checked_results;
	int error_cases;
	int fault_count;
	int unsigned cycle_cnt;
	int unsigned send_gap;
	int unsigned stall_left;
	bit idle_off;

	// Free running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Powers of the generator, then the discrete log of every element they reach.
	function automatic void build_field_tables();
		int unsigned x;
		x = 1;
		for (int unsigned i = 0; i < FIELD_MOD; i++) begin
			dlog_tab[i] = 0;
		end
		for (int unsigned i = 0; i < FIELD_MOD; i++) begin
			pow_tab[i] = x;
			x = (x * (FIELD_GEN % FIELD_MOD)) % FIELD_MOD;
		end
		for (int unsigned i = 0; i + 1 < FIELD_MOD; i++) begin
			dlog_tab[pow_tab[i]] = i;
		end
	endfunction

	// Result of one field operation; operands are first reduced modulo the prime.
	function automatic field_result_t field_op_result(input logic [OP_W-1:0] op,
			input logic [OPND_W-1:0] a_raw, input logic [OPND_W-1:0] b_raw);
		int unsigned a;
		int unsigned b;
		field_result_t r;
		a = a_raw % FIELD_MOD;
		b = b_raw % FIELD_MOD;
		r = '0;
		case (op)
			OP_ADD: begin
				r.value = RES_W'((a + b) % FIELD_MOD);
			end
			OP_SUB: begin
				r.value = RES_W'((FIELD_MOD + a - b) % FIELD_MOD);
			end
			OP_MUL: begin
				if (a != 0 && b != 0)
					r.value = RES_W'(pow_tab[(dlog_tab[a] + dlog_tab[b]) % (FIELD_MOD - 1)]);
			end
			OP_INV: begin
				if (a == 0)
					r.err = 1'b1;
				else
					r.value = RES_W'(pow_tab[(FIELD_MOD - 1 - dlog_tab[a]) % FIELD_MOD]);
			end
			OP_EXP: begin
				r.value = RES_W'(pow_tab[a]);
			end
			OP_LOG: begin
				if (a == 0)
					r.err = 1'b1;
				else
					r.value = RES_W'(dlog_tab[a]);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic add_req(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] a,
			input logic [OPND_W-1:0] b, input bit drain_first);
		field_req_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		r.drain_first = drain_first;
		pending_ops.push_back(r);
	endtask

	// Mostly in-range elements, with zero, the top element and unreduced codes favored.
	function automatic logic [OPND_W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return OPND_W'(FIELD_MOD - 1);
			2: return OPND_W'($urandom_range(FIELD_MOD, (1 << OPND_W) - 1));
			3: return OPND_W'($urandom_range(0, (1 << OPND_W) - 1));
			default: return OPND_W'($urandom_range(0, FIELD_MOD - 1));
		endcase
	endfunction

	function automatic logic [OP_W-1:0] rand_op();
		if ($urandom_range(0, 19) == 0)
			return ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
		return OP_W'($urandom_range(OP_ADD, OP_LOG));
	endfunction

	// Request driver: presents queued operations, records the expected result of each
	// accepted transaction, and inserts idle bursts or a full drain where asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid     <= 1'b0;
			req.req_type  <= '0;
			req.operand_a <= '0;
			req.operand_b <= '0;
			send_gap      <= 0;
			idle_off      <= 1'b0;
			cycle_cnt     <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			idle_off  <= (pending_ops.size() < TAIL_REQS) || (cycle_cnt[7:6] == 2'b11);
			if (req.valid && req.ready) begin
				predicted = field_op_result(req.req_type, req.operand_a, req.operand_b);
				awaited_results.push_back(predicted);
				accepted_reqs++;
				if (predicted.err)
					error_cases++;
			end
			// A new transaction may only be offered once the current one is gone.
			if (!req.valid || req.ready) begin
				if (send_gap != 0) begin
					req.valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (pending_ops.size() == 0) begin
					req.valid <= 1'b0;
				end else if (pending_ops[0].drain_first && awaited_results.size() != 0) begin
					req.valid <= 1'b0;
				end else if (!idle_off && $urandom_range(0, 5) == 0) begin
					req.valid <= 1'b0;
					send_gap  <= $urandom_range(0, 3);
				end else begin
					next_req = pending_ops.pop_front();
					req.valid     <= 1'b1;
					req.req_type  <= next_req.op;
					req.operand_a <= next_req.a;
					req.operand_b <= next_req.b;
				end
			end
		end
	end

	// Response monitor: checks each result transaction against the oldest expectation
	// and drives ready with random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				observed.value = rsp.result_value;
				observed.err   = rsp.error_flag;
				if (awaited_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: result with nothing expected: value %0d error %0b",
							$realtime, observed.value, observed.err);
				end else begin
					oldest = awaited_results.pop_front();
					checked_results++;
					if (observed.value !== oldest.value) begin
						fault_count++;
						if (fault_count <= 10)
							$display("%0t: result_value mismatch: expected %0d, got %0d",
								$realtime, oldest.value, observed.value);
					end
					if (observed.err !== oldest.err) begin
						fault_count++;
						if (fault_count <= 10)
							$display("%0t: error_flag mismatch: expected %0b, got %0b",
								$realtime, oldest.err, observed.err);
					end
				end
			end
			if (stall_left != 0) begin
				rsp.ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!idle_off && $urandom_range(0, 5) == 0) begin
				rsp.ready  <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.req_type   = '0;
		req.operand_a  = '0;
		req.operand_b  = '0;
		rsp.ready      = 1'b0;
		accepted_reqs  = 0;
		checked_results = 0;
		error_cases    = 0;
		fault_count    = 0;
		build_field_tables();

		// Directed: field extremes, every operation, zero and unreduced operands.
		add_req(OP_ADD, 10'd928, 10'd928, 1'b0);
		add_req(OP_ADD, 10'd0, 10'd0, 1'b0);
		add_req(OP_ADD, 10'd1023, 10'd1000, 1'b0);
		add_req(OP_SUB, 10'd0, 10'd928, 1'b0);
		add_req(OP_SUB, 10'd928, 10'd0, 1'b0);
		add_req(OP_SUB, 10'd5, 10'd1023, 1'b0);
		add_req(OP_MUL, 10'd0, 10'd77, 1'b0);
		add_req(OP_MUL, 10'd77, 10'd0, 1'b0);
		add_req(OP_MUL, 10'd928, 10'd928, 1'b0);
		add_req(OP_MUL, 10'd1023, 10'd929, 1'b0);
		add_req(OP_MUL, 10'd1000, 10'd2, 1'b0);
		add_req(OP_INV, 10'd0, 10'd0, 1'b0);
		add_req(OP_INV, 10'd1, 10'd1023, 1'b0);
		add_req(OP_INV, 10'd928, 10'd0, 1'b0);
		add_req(OP_INV, 10'd1023, 10'd512, 1'b0);
		add_req(OP_EXP, 10'd0, 10'd1023, 1'b0);
		add_req(OP_EXP, 10'd928, 10'd0, 1'b0);
		add_req(OP_EXP, 10'd1023, 10'd0, 1'b0);
		add_req(OP_LOG, 10'd0, 10'd0, 1'b0);
		add_req(OP_LOG, 10'd1, 10'd0, 1'b0);
		add_req(OP_LOG, 10'd928, 10'd1023, 1'b0);
		add_req(OP_LOG, 10'd929, 10'd0, 1'b0);
		add_req(OP_RSVD6, 10'd1023, 10'd1023, 1'b0);
		add_req(OP_RSVD7, 10'd5, 10'd7, 1'b0);

		// Random part; now and then the sender waits for the pipeline to run dry.
		for (int i = 0; i < RANDOM_REQS; i++)
			add_req(rand_op(), rand_operand(), rand_operand(), (i % 450) == 0);
		total_reqs = pending_ops.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_reqs < total_reqs) @(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (awaited_results.size() != 0)
			fault_count++;

		$display("Checked %0d results for %0d requests covering all eight operation codes,",
			checked_results, accepted_reqs);
		$display("including %0d log or inverse of zero cases; %0d mismatches.",
			error_cases, fault_count);
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: ends the run with an error if the stimulus has not finished it.
	initial begin
		#8000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
